FILE: sv/mcf_pkg.sv
// ---------------------------------------------------------------------------
// mcf_pkg
// Shared types and codes for the multicycle control state machine.
// ---------------------------------------------------------------------------
package mcf_pkg;

  typedef logic [5:0] opcode_t;
  typedef logic [5:0] funct_t;
  typedef logic [2:0] alu_class_t;
  typedef logic [2:0] alu_ctl_t;

  typedef enum logic [3:0] {
    S_FETCH     = 4'd0,
    S_DECODE    = 4'd1,
    S_MEM_ADDR  = 4'd2,
    S_MEM_READ  = 4'd3,
    S_MEM_WB    = 4'd4,
    S_MEM_WRITE = 4'd5,
    S_R_EXEC    = 4'd6,
    S_ALU_WB    = 4'd7,
    S_BEQ       = 4'd8,
    S_ADDI_EXEC = 4'd9,
    S_IMM_WB    = 4'd10,
    S_JUMP      = 4'd11,
    S_ORI       = 4'd12,
    S_XORI      = 4'd13,
    S_SLTI      = 4'd14,
    S_BNE       = 4'd15
  } state_t;

  localparam opcode_t OP_RTYPE = 6'h00;
  localparam opcode_t OP_J     = 6'h02;
  localparam opcode_t OP_BEQ   = 6'h04;
  localparam opcode_t OP_BNE   = 6'h05;
  localparam opcode_t OP_ADDI  = 6'h08;
  localparam opcode_t OP_SLTI  = 6'h0A;
  localparam opcode_t OP_ORI   = 6'h0D;
  localparam opcode_t OP_XORI  = 6'h0E;
  localparam opcode_t OP_LW    = 6'h23;
  localparam opcode_t OP_SW    = 6'h2B;

  localparam funct_t FN_ADD = 6'h20;
  localparam funct_t FN_SUB = 6'h22;
  localparam funct_t FN_AND = 6'h24;
  localparam funct_t FN_OR  = 6'h25;
  localparam funct_t FN_XOR = 6'h26;
  localparam funct_t FN_NOR = 6'h27;
  localparam funct_t FN_SLT = 6'h2A;

  localparam alu_class_t CLS_ADD   = 3'd0;
  localparam alu_class_t CLS_SUB   = 3'd1;
  localparam alu_class_t CLS_FUNCT = 3'd2;
  localparam alu_class_t CLS_SLT   = 3'd3;
  localparam alu_class_t CLS_BNE   = 3'd4;
  localparam alu_class_t CLS_OR    = 3'd6;
  localparam alu_class_t CLS_XOR   = 3'd7;

  localparam alu_ctl_t ALU_AND = 3'd0;
  localparam alu_ctl_t ALU_OR  = 3'd1;
  localparam alu_ctl_t ALU_ADD = 3'd2;
  localparam alu_ctl_t ALU_XOR = 3'd3;
  localparam alu_ctl_t ALU_NOR = 3'd4;
  localparam alu_ctl_t ALU_SUB = 3'd6;
  localparam alu_ctl_t ALU_SLT = 3'd7;

  localparam logic [1:0] PCS_ALU     = 2'd0;
  localparam logic [1:0] PCS_ALU_OUT = 2'd1;
  localparam logic [1:0] PCS_JUMP    = 2'd2;

  localparam logic [1:0] BR_NONE = 2'd0;
  localparam logic [1:0] BR_EQ   = 2'd1;
  localparam logic [1:0] BR_NE   = 2'd2;

  localparam logic [1:0] SRCB_REG   = 2'd0;
  localparam logic [1:0] SRCB_FOUR  = 2'd1;
  localparam logic [1:0] SRCB_IMM   = 2'd2;
  localparam logic [1:0] SRCB_IMMSH = 2'd3;

  typedef struct packed {
    logic       mem_to_reg;
    logic       reg_dst;
    logic       inst_or_data;
    logic [1:0] pc_source;
    logic       alu_src_a;
    logic       ir_write;
    logic       mem_write;
    logic       pc_write;
    logic [1:0] branch_mode;
    logic       reg_write;
    logic [1:0] alu_src_b;
    alu_class_t alu_class;
  } ctrl_t;

  typedef struct packed {
    logic       mem_to_reg;
    logic       reg_dst;
    logic       inst_or_data;
    logic [1:0] pc_source;
    logic       alu_src_a;
    logic       ir_write;
    logic       mem_write;
    logic       pc_write;
    logic [1:0] branch_mode;
    logic       reg_write;
    logic [1:0] alu_src_b;
    alu_ctl_t   alu_control;
  } out_word_t;

endpackage

FILE: sv/mcf_in_if.sv
// ---------------------------------------------------------------------------
// mcf_in_if
// Input channel: one word per clock edge of the controlled datapath.
// ---------------------------------------------------------------------------
interface mcf_in_if;
  logic             valid;
  logic             ready;
  logic             reset_req;
  mcf_pkg::opcode_t opcode;
  mcf_pkg::funct_t  funct_code;

  modport source (output valid, output reset_req, output opcode, output funct_code,
                  input ready);
  modport sink   (input valid, input reset_req, input opcode, input funct_code,
                  output ready);
endinterface

FILE: sv/mcf_out_if.sv
// ---------------------------------------------------------------------------
// mcf_out_if
// Result channel: datapath control word for one clock edge.
// ---------------------------------------------------------------------------
interface mcf_out_if;
  logic              valid;
  logic              ready;
  logic              mem_to_reg;
  logic              reg_dst;
  logic              inst_or_data;
  logic [1:0]        pc_source;
  logic              alu_src_a;
  logic              ir_write;
  logic              mem_write;
  logic              pc_write;
  logic [1:0]        branch_mode;
  logic              reg_write;
  logic [1:0]        alu_src_b;
  mcf_pkg::alu_ctl_t alu_control;

  modport source (output valid, output mem_to_reg, output reg_dst, output inst_or_data,
                  output pc_source, output alu_src_a, output ir_write, output mem_write,
                  output pc_write, output branch_mode, output reg_write,
                  output alu_src_b, output alu_control, input ready);
  modport sink   (input valid, input mem_to_reg, input reg_dst, input inst_or_data,
                  input pc_source, input alu_src_a, input ir_write, input mem_write,
                  input pc_write, input branch_mode, input reg_write,
                  input alu_src_b, input alu_control, output ready);
endinterface

FILE: sv/mcf_ctrl.sv
// ---------------------------------------------------------------------------
// mcf_ctrl
// Per-state control row and next-state selection.
// ---------------------------------------------------------------------------
module mcf_ctrl (
  input  mcf_pkg::state_t  state,
  input  mcf_pkg::opcode_t opcode,
  output mcf_pkg::ctrl_t   row,
  output mcf_pkg::state_t  state_next
);

  always_comb begin
    row = '0;
    unique case (state)
      mcf_pkg::S_FETCH: begin
        row.ir_write  = 1'b1;
        row.pc_write  = 1'b1;
        row.alu_src_b = mcf_pkg::SRCB_FOUR;
      end
      mcf_pkg::S_DECODE: begin
        row.alu_src_b = mcf_pkg::SRCB_IMMSH;
      end
      mcf_pkg::S_MEM_ADDR, mcf_pkg::S_ADDI_EXEC: begin
        row.alu_src_a = 1'b1;
        row.alu_src_b = mcf_pkg::SRCB_IMM;
      end
      mcf_pkg::S_MEM_READ: begin
        row.inst_or_data = 1'b1;
      end
      mcf_pkg::S_MEM_WB: begin
        row.mem_to_reg = 1'b1;
        row.reg_write  = 1'b1;
      end
      mcf_pkg::S_MEM_WRITE: begin
        row.inst_or_data = 1'b1;
        row.mem_write    = 1'b1;
      end
      mcf_pkg::S_R_EXEC: begin
        row.alu_src_a = 1'b1;
        row.alu_class = mcf_pkg::CLS_FUNCT;
      end
      mcf_pkg::S_ALU_WB: begin
        row.reg_dst   = 1'b1;
        row.reg_write = 1'b1;
      end
      mcf_pkg::S_BEQ: begin
        row.pc_source   = mcf_pkg::PCS_ALU_OUT;
        row.alu_src_a   = 1'b1;
        row.branch_mode = mcf_pkg::BR_EQ;
        row.alu_class   = mcf_pkg::CLS_SUB;
      end
      mcf_pkg::S_IMM_WB: begin
        row.reg_write = 1'b1;
      end
      mcf_pkg::S_JUMP: begin
        row.pc_source = mcf_pkg::PCS_JUMP;
        row.pc_write  = 1'b1;
      end
      mcf_pkg::S_ORI: begin
        row.alu_src_a = 1'b1;
        row.alu_src_b = mcf_pkg::SRCB_IMM;
        row.alu_class = mcf_pkg::CLS_OR;
      end
      mcf_pkg::S_XORI: begin
        row.alu_src_a = 1'b1;
        row.alu_src_b = mcf_pkg::SRCB_IMM;
        row.alu_class = mcf_pkg::CLS_XOR;
      end
      mcf_pkg::S_SLTI: begin
        row.alu_src_a = 1'b1;
        row.alu_src_b = mcf_pkg::SRCB_IMM;
        row.alu_class = mcf_pkg::CLS_SLT;
      end
      mcf_pkg::S_BNE: begin
        row.pc_source   = mcf_pkg::PCS_ALU_OUT;
        row.alu_src_a   = 1'b1;
        row.branch_mode = mcf_pkg::BR_NE;
        row.alu_class   = mcf_pkg::CLS_BNE;
      end
    endcase
  end

  always_comb begin
    state_next = mcf_pkg::S_FETCH;
    unique case (state)
      mcf_pkg::S_FETCH:     state_next = mcf_pkg::S_DECODE;
      mcf_pkg::S_DECODE: begin
        unique case (opcode)
          mcf_pkg::OP_LW,
          mcf_pkg::OP_SW:    state_next = mcf_pkg::S_MEM_ADDR;
          mcf_pkg::OP_RTYPE: state_next = mcf_pkg::S_R_EXEC;
          mcf_pkg::OP_BEQ:   state_next = mcf_pkg::S_BEQ;
          mcf_pkg::OP_ADDI:  state_next = mcf_pkg::S_ADDI_EXEC;
          mcf_pkg::OP_J:     state_next = mcf_pkg::S_JUMP;
          mcf_pkg::OP_ORI:   state_next = mcf_pkg::S_ORI;
          mcf_pkg::OP_XORI:  state_next = mcf_pkg::S_XORI;
          mcf_pkg::OP_SLTI:  state_next = mcf_pkg::S_SLTI;
          mcf_pkg::OP_BNE:   state_next = mcf_pkg::S_BNE;
          default:           state_next = mcf_pkg::S_FETCH;
        endcase
      end
      mcf_pkg::S_MEM_ADDR: begin
        priority if (opcode == mcf_pkg::OP_LW) state_next = mcf_pkg::S_MEM_READ;
        else if (opcode == mcf_pkg::OP_SW)     state_next = mcf_pkg::S_MEM_WRITE;
        else                                   state_next = mcf_pkg::S_FETCH;
      end
      mcf_pkg::S_MEM_READ:  state_next = mcf_pkg::S_MEM_WB;
      mcf_pkg::S_R_EXEC:    state_next = mcf_pkg::S_ALU_WB;
      mcf_pkg::S_ADDI_EXEC,
      mcf_pkg::S_ORI,
      mcf_pkg::S_XORI,
      mcf_pkg::S_SLTI:      state_next = mcf_pkg::S_IMM_WB;
      default:              state_next = mcf_pkg::S_FETCH;
    endcase
  end

endmodule

FILE: sv/mcf_alu_dec.sv
// ---------------------------------------------------------------------------
// mcf_alu_dec
// ALU decoder: operation class and funct field to ALU control code.
// ---------------------------------------------------------------------------
module mcf_alu_dec (
  input  mcf_pkg::alu_class_t alu_class,
  input  mcf_pkg::funct_t     funct_code,
  output mcf_pkg::alu_ctl_t   alu_control
);

  always_comb begin
    alu_control = mcf_pkg::ALU_AND;
    unique case (alu_class)
      mcf_pkg::CLS_ADD: alu_control = mcf_pkg::ALU_ADD;
      mcf_pkg::CLS_SUB: alu_control = mcf_pkg::ALU_SUB;
      mcf_pkg::CLS_FUNCT: begin
        unique case (funct_code)
          mcf_pkg::FN_ADD: alu_control = mcf_pkg::ALU_ADD;
          mcf_pkg::FN_SUB: alu_control = mcf_pkg::ALU_SUB;
          mcf_pkg::FN_AND: alu_control = mcf_pkg::ALU_AND;
          mcf_pkg::FN_OR:  alu_control = mcf_pkg::ALU_OR;
          mcf_pkg::FN_SLT: alu_control = mcf_pkg::ALU_SLT;
          mcf_pkg::FN_XOR: alu_control = mcf_pkg::ALU_XOR;
          mcf_pkg::FN_NOR: alu_control = mcf_pkg::ALU_NOR;
          default:         alu_control = mcf_pkg::ALU_AND;
        endcase
      end
      mcf_pkg::CLS_SLT: alu_control = mcf_pkg::ALU_SLT;
      mcf_pkg::CLS_BNE: alu_control = mcf_pkg::ALU_SUB;
      mcf_pkg::CLS_OR:  alu_control = mcf_pkg::ALU_OR;
      mcf_pkg::CLS_XOR: alu_control = mcf_pkg::ALU_XOR;
      default:          alu_control = mcf_pkg::ALU_AND;
    endcase
  end

endmodule

FILE: sv/multicycle_cpu_control_fsm.sv
// ---------------------------------------------------------------------------
// multicycle_cpu_control_fsm
// Multicycle processor control state machine with output word register.
//
//   channel  dir  payload
//   in_ch    in   reset_req, opcode, funct_code
//   out_ch   out  mem_to_reg .. alu_src_b, alu_control
//
// One word in, one word out; a new word is taken every cycle while the output word is not stalled.
// The state register and the output register load on the same edge.
// The output word register holds the control word and shows it in the cycle after the input word is taken.
// rst_n clears the state to fetch and empties the output register.
// A stalled output word blocks input only while out_ch.ready is low.
// ---------------------------------------------------------------------------
module multicycle_cpu_control_fsm (
  input  logic               clk,
  input  logic               rst_n,
  mcf_in_if.sink             in_ch,
  mcf_out_if.source          out_ch
);

  mcf_pkg::state_t    state_r;
  mcf_pkg::state_t    state_nxt;
  mcf_pkg::state_t    state_cur;
  mcf_pkg::ctrl_t     row;
  mcf_pkg::alu_ctl_t  alu_ctl;
  mcf_pkg::out_word_t out_r;
  mcf_pkg::out_word_t out_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               in_ready;
  logic               in_acc;

  assign state_cur = in_ch.reset_req ? mcf_pkg::S_FETCH : state_r;

  mcf_ctrl u_ctrl (
    .state      (state_cur),
    .opcode     (in_ch.opcode),
    .row        (row),
    .state_next (state_nxt)
  );

  mcf_alu_dec u_alu_dec (
    .alu_class   (row.alu_class),
    .funct_code  (in_ch.funct_code),
    .alu_control (alu_ctl)
  );

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    out_nxt.mem_to_reg   = row.mem_to_reg;
    out_nxt.reg_dst      = row.reg_dst;
    out_nxt.inst_or_data = row.inst_or_data;
    out_nxt.pc_source    = row.pc_source;
    out_nxt.alu_src_a    = row.alu_src_a;
    out_nxt.ir_write     = row.ir_write;
    out_nxt.mem_write    = row.mem_write;
    out_nxt.pc_write     = row.pc_write;
    out_nxt.branch_mode  = row.branch_mode;
    out_nxt.reg_write    = row.reg_write;
    out_nxt.alu_src_b    = row.alu_src_b;
    out_nxt.alu_control  = alu_ctl;
    out_valid_nxt        = in_acc || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcf_pkg::S_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mem_to_reg   = out_r.mem_to_reg;
  assign out_ch.reg_dst      = out_r.reg_dst;
  assign out_ch.inst_or_data = out_r.inst_or_data;
  assign out_ch.pc_source    = out_r.pc_source;
  assign out_ch.alu_src_a    = out_r.alu_src_a;
  assign out_ch.ir_write     = out_r.ir_write;
  assign out_ch.mem_write    = out_r.mem_write;
  assign out_ch.pc_write     = out_r.pc_write;
  assign out_ch.branch_mode  = out_r.branch_mode;
  assign out_ch.reg_write    = out_r.reg_write;
  assign out_ch.alu_src_b    = out_r.alu_src_b;
  assign out_ch.alu_control  = out_r.alu_control;

`ifndef SYNTHESIS
  a_reset_word_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.reset_req |=> out_ch.valid && out_ch.ir_write && out_ch.pc_write)
    else $error("reset word did not produce a fetch control word");

  a_fetch_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && state_cur == mcf_pkg::S_FETCH |=> state_r == mcf_pkg::S_DECODE)
    else $error("fetch did not advance to decode");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r))
    else $error("state moved without an accepted word");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output word stalled");
`endif

endmodule
